>>> design/ibrsr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// iBUS receiver with sensor responder. No dependencies.
package ibrsr_pkg;

    localparam int FRAME_SIZE  = 32;
    localparam int CHANNELS    = 14;
    localparam int MAX_SENSORS = 8;

    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = 5;
    localparam int CH_W      = 4;
    localparam int TX_W      = 3;
    localparam int SNS_AW    = 3;

    localparam logic [7:0] CMD_SERVO   = 8'h40;
    localparam logic [3:0] CMD_DISCOVER = 4'h8;
    localparam logic [3:0] CMD_TYPE    = 4'h9;
    localparam logic [3:0] CMD_VALUE   = 4'hA;
    localparam logic [7:0] OVERHEAD    = 8'd3;

    // Input transaction kinds.
    localparam logic [1:0] IN_BYTE  = 2'd0;
    localparam logic [1:0] IN_TICK  = 2'd1;
    localparam logic [1:0] IN_VALUE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SENSOR_COUNT = 3'd0;
    localparam logic [2:0] REG_SENSOR_TYPES = 3'd1;
    localparam logic [2:0] REG_WIDE_MASK    = 3'd2;
    localparam logic [2:0] REG_GAP_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_REPLY_ENABLE = 3'd4;

    typedef struct packed {
        logic              take;       // input transaction accepted
        logic              rd_en;
        logic [BUF_AW-1:0] rd_addr;
        logic              latch_lo;   // capture low channel byte from buffer
        logic              load_chan;  // load channel result using buffer data
        logic [CH_W-1:0]   chan;
        logic              load_reply;
        logic [TX_W-1:0]   tx;
        logic              clr_sum;
        logic              load_err;
    } t_ctrl_cmd;

    typedef struct packed {
        logic frame_done;
        logic frame_good;
        logic is_servo;
        logic reply_ok;
        logic reply_last;
        logic out_taken;
    } t_dp_status;

endpackage

>>> design/ibus_receiver_sensor_responder_top.sv
// Top level of the iBUS receiver with sensor telemetry responder.
// Depends on ibrsr_pkg, ibrsr_ctrl and ibrsr_datapath.

// A completed servo frame emits 14 channel words, each by two reads of the
// body buffer RAM, a load, and the output transaction, which may stall on the
// output. A sensor reply is four to eight bytes, each loaded and then sent.
// No input transaction is taken until the last result of a frame has been
// delivered.
module ibus_receiver_sensor_responder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] rx_byte, [11:8] sensor_address, [43:12] sensor_value, rest zero
    input  logic [47:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] channel_index, [19:4] channel_value, [27:20] reply_byte,
    // [59:28] good_frame_count, [91:60] error_frame_count, rest zero
    output logic [95:0]  m_axis_tdata,
    // [1:0] kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    ibrsr_pkg::t_ctrl_cmd  cmd;
    ibrsr_pkg::t_dp_status stat;
    logic [3:0]  chan_idx;
    logic [15:0] chan_val;
    logic [7:0]  reply;
    logic [31:0] good, errs;

    ibrsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ibrsr_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_cmd         (s_axis_tuser),
        .i_rx_byte        (s_axis_tdata[7:0]),
        .i_sensor_address (s_axis_tdata[11:8]),
        .i_sensor_value   (s_axis_tdata[43:12]),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_kind           (m_axis_tuser),
        .o_channel_index  (chan_idx),
        .o_channel_value  (chan_val),
        .o_reply_byte     (reply),
        .o_last           (m_axis_tlast),
        .o_good_count     (good),
        .o_error_count    (errs)
    );

    assign m_axis_tdata = {4'h0, errs, good, reply, chan_val, chan_idx};
endmodule

>>> design/ibrsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ibrsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> design/ibrsr_datapath.sv
// Datapath: configuration, frame parsing, counters, sensor values, body
// buffer and the result register. Depends on ibrsr_pkg and ibrsr_ram.
module ibrsr_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_wdata,
    input  logic [1:0]            i_in_cmd,
    input  logic [7:0]            i_rx_byte,
    input  logic [3:0]            i_sensor_address,
    input  logic [31:0]           i_sensor_value,
    input  ibrsr_pkg::t_ctrl_cmd  i_cmd,
    output ibrsr_pkg::t_dp_status o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [1:0]            o_kind,
    output logic [3:0]            o_channel_index,
    output logic [15:0]           o_channel_value,
    output logic [7:0]            o_reply_byte,
    output logic                  o_last,
    output logic [31:0]           o_good_count,
    output logic [31:0]           o_error_count
);
    typedef enum logic [1:0] {PH_LEN, PH_DATA, PH_CHKL, PH_CHKH} t_phase;

    logic [3:0]  r_sensor_count;
    logic [63:0] r_sensor_types;
    logic [7:0]  r_wide_mask;
    logic [7:0]  r_gap_timeout;
    logic        r_reply_enable;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_body_len, r_body_idx;
    logic [15:0] r_run_sum;
    logic [7:0]  r_chk_low;
    logic [7:0]  r_idle_ms;
    logic [31:0] r_good, r_error;
    logic [7:0]  r_frame_cmd;
    logic [31:0] r_sensor [ibrsr_pkg::MAX_SENSORS];
    logic [ibrsr_pkg::BUF_DEPTH-1:0] r_buf_valid;
    logic        r_rd_valid;
    logic [7:0]  r_chan_lo;
    logic [15:0] r_tx_sum;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [3:0]  r_chan_idx;
    logic [15:0] r_chan_val;
    logic [7:0]  r_reply;
    logic        r_last;

    logic        byte_in, wr_en;
    logic [7:0]  rd_byte, ram_q;
    logic [3:0]  active, adr, val_adr;
    logic [2:0]  sidx, vidx;
    logic [7:0]  stype, slen;
    logic        wide;
    logic [31:0] sval;
    logic [2:0]  ndata;
    logic [7:0]  tx_byte;
    logic        tx_is_data;
    logic [15:0] chk;

    assign byte_in = i_cmd.take && (i_in_cmd == ibrsr_pkg::IN_BYTE);
    assign active  = (r_sensor_count > 4'(ibrsr_pkg::MAX_SENSORS)) ?
                     4'(ibrsr_pkg::MAX_SENSORS) : r_sensor_count;

    // A long enough idle gap forces the byte to be taken as a length byte.
    assign n_phase = (r_idle_ms >= r_gap_timeout) ? PH_LEN : r_phase;
    assign wr_en   = byte_in && (n_phase == PH_DATA);

    ibrsr_ram #(.WIDTH(8), .DEPTH(ibrsr_pkg::BUF_DEPTH)) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_body_idx),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (ram_q)
    );
    assign rd_byte = r_rd_valid ? ram_q : 8'h00;

    // Sensor reply bytes.
    assign adr   = r_frame_cmd[3:0];
    assign sidx  = 3'(adr - 4'd1);
    assign stype = r_sensor_types[sidx*8 +: 8];
    assign wide  = r_wide_mask[sidx];
    assign slen  = wide ? 8'd4 : 8'd2;
    assign sval  = r_sensor[sidx];
    assign chk   = ~r_tx_sum;

    always_comb begin
        ndata   = 3'd2;
        tx_byte = 8'h00;
        unique case (r_frame_cmd[7:4])
            ibrsr_pkg::CMD_TYPE: begin
                ndata = 3'd4;
                unique case (i_cmd.tx[1:0])
                    2'd0: tx_byte = 8'h06;
                    2'd1: tx_byte = {ibrsr_pkg::CMD_TYPE, adr};
                    2'd2: tx_byte = stype;
                    default: tx_byte = slen;
                endcase
            end
            ibrsr_pkg::CMD_VALUE: begin
                ndata = wide ? 3'd6 : 3'd4;
                unique case (i_cmd.tx)
                    3'd0: tx_byte = 8'h04 + slen;
                    3'd1: tx_byte = {ibrsr_pkg::CMD_VALUE, adr};
                    3'd2: tx_byte = sval[7:0];
                    3'd3: tx_byte = sval[15:8];
                    3'd4: tx_byte = sval[23:16];
                    default: tx_byte = sval[31:24];
                endcase
            end
            default: begin
                ndata   = 3'd2;
                tx_byte = i_cmd.tx[0] ? {ibrsr_pkg::CMD_DISCOVER, adr} : 8'h04;
            end
        endcase
    end

    assign tx_is_data = (i_cmd.tx < ndata);

    always_comb begin
        o_stat.frame_done = byte_in && (n_phase == PH_CHKH);
        o_stat.frame_good = (r_run_sum == {i_rx_byte, r_chk_low});
        o_stat.is_servo   = (r_frame_cmd == ibrsr_pkg::CMD_SERVO);
        o_stat.reply_ok   = r_reply_enable && (adr != 4'd0) && (adr <= active)
                            && (r_body_len == 5'd1)
                            && ((r_frame_cmd[7:4] == ibrsr_pkg::CMD_DISCOVER)
                             || (r_frame_cmd[7:4] == ibrsr_pkg::CMD_TYPE)
                             || (r_frame_cmd[7:4] == ibrsr_pkg::CMD_VALUE));
        o_stat.reply_last = ({1'b0, i_cmd.tx} == ({1'b0, ndata} + 4'd1));
        o_stat.out_taken  = r_out_valid && i_out_ready;
    end

    assign val_adr = i_sensor_address;
    assign vidx    = 3'(val_adr - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count <= '0;
            r_sensor_types <= '0;
            r_wide_mask    <= '0;
            r_gap_timeout  <= 8'd3;
            r_reply_enable <= 1'b1;
            r_phase        <= PH_LEN;
            r_body_len     <= '0;
            r_body_idx     <= '0;
            r_run_sum      <= '0;
            r_chk_low      <= '0;
            r_idle_ms      <= '0;
            r_good         <= '0;
            r_error        <= '0;
            r_frame_cmd    <= '0;
            r_buf_valid    <= '0;
            r_rd_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_tx_sum       <= '0;
            for (int i = 0; i < ibrsr_pkg::MAX_SENSORS; i++) begin
                r_sensor[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    ibrsr_pkg::REG_SENSOR_COUNT: r_sensor_count <= i_cfg_wdata[3:0];
                    ibrsr_pkg::REG_SENSOR_TYPES: r_sensor_types <= i_cfg_wdata;
                    ibrsr_pkg::REG_WIDE_MASK:    r_wide_mask    <= i_cfg_wdata[7:0];
                    ibrsr_pkg::REG_GAP_TIMEOUT:  r_gap_timeout  <= i_cfg_wdata[7:0];
                    ibrsr_pkg::REG_REPLY_ENABLE: r_reply_enable <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_cmd.take && (i_in_cmd == ibrsr_pkg::IN_TICK)
                && (r_idle_ms != 8'hFF)) begin
                r_idle_ms <= r_idle_ms + 8'd1;
            end
            if (i_cmd.take && (i_in_cmd == ibrsr_pkg::IN_VALUE)
                && (val_adr != 4'd0) && (val_adr <= active)) begin
                r_sensor[vidx] <= i_sensor_value;
            end

            if (byte_in) begin
                r_idle_ms <= '0;
                unique case (n_phase)
                    PH_LEN: begin
                        r_phase <= PH_LEN;
                        if ((i_rx_byte <= 8'(ibrsr_pkg::FRAME_SIZE))
                            && (i_rx_byte > ibrsr_pkg::OVERHEAD)) begin
                            r_body_idx <= '0;
                            r_body_len <= 5'(i_rx_byte - ibrsr_pkg::OVERHEAD);
                            r_run_sum  <= 16'hFFFF - {8'h00, i_rx_byte};
                            r_phase    <= PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        r_buf_valid[r_body_idx] <= 1'b1;
                        if (r_body_idx == '0) begin
                            r_frame_cmd <= i_rx_byte;
                        end
                        r_body_idx <= r_body_idx + 5'd1;
                        r_run_sum  <= r_run_sum - {8'h00, i_rx_byte};
                        r_phase    <= ((r_body_idx + 5'd1) >= r_body_len) ?
                                      PH_CHKL : PH_DATA;
                    end
                    PH_CHKL: begin
                        r_chk_low <= i_rx_byte;
                        r_phase   <= PH_CHKH;
                    end
                    default: begin
                        r_phase <= PH_LEN;
                        if (o_stat.frame_good) begin
                            if (r_good != '1) r_good <= r_good + 32'd1;
                        end else begin
                            if (r_error != '1) r_error <= r_error + 32'd1;
                        end
                    end
                endcase
            end

            if (i_cmd.rd_en) begin
                r_rd_valid <= r_buf_valid[i_cmd.rd_addr];
            end

            if (i_cmd.clr_sum) begin
                r_tx_sum <= '0;
            end else if (i_cmd.load_reply && tx_is_data) begin
                r_tx_sum <= r_tx_sum + {8'h00, tx_byte};
            end

            if (i_cmd.load_chan || i_cmd.load_reply || i_cmd.load_err) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_lo) begin
            r_chan_lo <= rd_byte;
        end
        if (i_cmd.load_chan) begin
            r_kind     <= ibrsr_pkg::KIND_CHANNEL;
            r_chan_idx <= i_cmd.chan;
            r_chan_val <= {rd_byte, r_chan_lo};
            r_reply    <= '0;
            r_last     <= (i_cmd.chan == 4'(ibrsr_pkg::CHANNELS - 1));
        end else if (i_cmd.load_reply) begin
            r_kind     <= ibrsr_pkg::KIND_REPLY;
            r_chan_idx <= '0;
            r_chan_val <= '0;
            r_reply    <= tx_is_data ? tx_byte :
                          ((i_cmd.tx == ndata) ? chk[7:0] : chk[15:8]);
            r_last     <= o_stat.reply_last;
        end else if (i_cmd.load_err) begin
            r_kind     <= ibrsr_pkg::KIND_ERROR;
            r_chan_idx <= '0;
            r_chan_val <= '0;
            r_reply    <= '0;
            r_last     <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_channel_index = r_chan_idx;
    assign o_channel_value = r_chan_val;
    assign o_reply_byte    = r_reply;
    assign o_last          = r_last;
    // Counters cannot move while results are pending, so they are read live.
    assign o_good_count    = r_good;
    assign o_error_count   = r_error;
endmodule

>>> design/ibrsr_ctrl.sv
// Controller: accepts input transactions and sequences channel, reply and
// error results. Depends on ibrsr_pkg.
module ibrsr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ibrsr_pkg::t_dp_status i_stat,
    output ibrsr_pkg::t_ctrl_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_CH_A, S_CH_B, S_CH_C, S_CH_W, S_RP_LOAD, S_RP_W, S_ER_W
    } t_state;

    t_state r_state;
    logic [ibrsr_pkg::CH_W-1:0] r_chan;
    logic [ibrsr_pkg::TX_W-1:0] r_tx;
    logic take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.take       = take;
        o_cmd.chan       = r_chan;
        o_cmd.tx         = r_tx;
        o_cmd.load_err   = take && i_stat.frame_done && !i_stat.frame_good;
        o_cmd.clr_sum    = take && i_stat.frame_done;
        o_cmd.rd_en      = (r_state == S_CH_A) || (r_state == S_CH_B);
        o_cmd.rd_addr    = (r_state == S_CH_A) ? {r_chan, 1'b1}
                                               : ({r_chan, 1'b1} + 5'd1);
        o_cmd.latch_lo   = (r_state == S_CH_B);
        o_cmd.load_chan  = (r_state == S_CH_C);
        o_cmd.load_reply = (r_state == S_RP_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= '0;
            r_tx    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take && i_stat.frame_done) begin
                        r_chan <= '0;
                        r_tx   <= '0;
                        priority if (!i_stat.frame_good) r_state <= S_ER_W;
                        else if (i_stat.is_servo)        r_state <= S_CH_A;
                        else if (i_stat.reply_ok)        r_state <= S_RP_LOAD;
                        else                             r_state <= S_IDLE;
                    end
                end
                S_CH_A: r_state <= S_CH_B;
                S_CH_B: r_state <= S_CH_C;
                S_CH_C: r_state <= S_CH_W;
                S_CH_W: begin
                    if (i_stat.out_taken) begin
                        if (r_chan == 4'(ibrsr_pkg::CHANNELS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_chan  <= r_chan + 4'd1;
                            r_state <= S_CH_A;
                        end
                    end
                end
                S_RP_LOAD: r_state <= S_RP_W;
                S_RP_W: begin
                    if (i_stat.out_taken) begin
                        if (i_stat.reply_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_tx    <= r_tx + 3'd1;
                            r_state <= S_RP_LOAD;
                        end
                    end
                end
                S_ER_W: begin
                    if (i_stat.out_taken) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> dv/tb_ibus_receiver_sensor_responder_top.sv
// Self-checking testbench for the iBUS receiver with sensor telemetry responder.
// Depends on ibrsr_pkg and ibus_receiver_sensor_responder_top; predicts results in place.
module tb_ibus_receiver_sensor_responder_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Input code that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {P_LEN, P_DATA, P_CHKL, P_CHKH} t_rx_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  chan;
        logic [15:0] value;
        logic [7:0]  rbyte;
        logic        last;
        logic [31:0] good;
        logic [31:0] bad;
    } t_result;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rx;
        logic [3:0]  adr;
        logic [31:0] val;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    ibus_receiver_sensor_responder_top u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    logic [3:0]  cfg_count;
    logic [63:0] cfg_types;
    logic [7:0]  cfg_wide;
    logic [7:0]  cfg_gap;
    logic        cfg_reply;
    t_rx_phase   phase;
    logic [4:0]  body_len;
    logic [4:0]  body_idx;
    logic [15:0] run_sum;
    logic [7:0]  chk_lo;
    logic [7:0]  body [32];
    logic [31:0] sensor_val [8];
    logic [7:0]  idle_ms;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      frames_sent = 0;
    int      tx_idle_pct = 12;
    int      rx_idle_pct = 61;
    bit      hold_tx = 1'b0;
    int      stuck_cycles = 0;

    task automatic push_result(logic [1:0] kind, logic [3:0] ch, logic [15:0] v,
                               logic [7:0] rb, logic lst);
        t_result r;
        r.kind = kind; r.chan = ch; r.value = v; r.rbyte = rb; r.last = lst;
        r.good = good_cnt; r.bad = bad_cnt;
        expected_results.push_back(r);
    endtask

    task automatic predict_reply();
        logic [7:0]  tx [8];
        int          n;
        logic [3:0]  adr;
        logic [7:0]  typ;
        logic [7:0]  vlen;
        logic [31:0] v;
        logic [15:0] sum;
        logic [3:0]  act;
        n = 0; sum = '0;
        adr = body[0][3:0];
        act = (cfg_count > 4'd8) ? 4'd8 : cfg_count;
        if (!cfg_reply || adr == 0 || adr > act || body_len != 5'd1)
            return;
        typ = cfg_types[(adr - 1) * 8 +: 8];
        vlen = cfg_wide[adr - 1] ? 8'd4 : 8'd2;
        v = sensor_val[adr - 1];
        case (body[0][7:4])
            ibrsr_pkg::CMD_DISCOVER: begin
                tx[0] = 8'h04; tx[1] = 8'h80 + adr; n = 2;
            end
            ibrsr_pkg::CMD_TYPE: begin
                tx[0] = 8'h06; tx[1] = 8'h90 + adr; tx[2] = typ; tx[3] = vlen; n = 4;
            end
            ibrsr_pkg::CMD_VALUE: begin
                tx[0] = 8'h04 + vlen; tx[1] = 8'hA0 + adr;
                tx[2] = v[7:0]; tx[3] = v[15:8]; n = 4;
                if (vlen == 8'd4) begin
                    tx[4] = v[23:16]; tx[5] = v[31:24]; n = 6;
                end
            end
            default: return;
        endcase
        for (int i = 0; i < n; i++) sum += tx[i];
        sum = 16'hFFFF - sum;
        tx[n] = sum[7:0]; tx[n + 1] = sum[15:8];
        for (int i = 0; i < n + 2; i++)
            push_result(ibrsr_pkg::KIND_REPLY, '0, '0, tx[i], i == n + 1);
    endtask

    task automatic predict_item(t_item it);
        logic [3:0] act;
        act = (cfg_count > 4'd8) ? 4'd8 : cfg_count;
        if (it.op == ibrsr_pkg::IN_TICK) begin
            if (idle_ms != 8'hFF) idle_ms++;
        end else if (it.op == ibrsr_pkg::IN_VALUE) begin
            if (it.adr != 0 && it.adr <= act) sensor_val[it.adr - 1] = it.val;
        end else if (it.op == ibrsr_pkg::IN_BYTE) begin
            if (idle_ms >= cfg_gap) phase = P_LEN;
            idle_ms = '0;
            case (phase)
                P_LEN: if (it.rx <= ibrsr_pkg::FRAME_SIZE && it.rx > ibrsr_pkg::OVERHEAD) begin
                    body_idx = '0;
                    body_len = 5'(it.rx - ibrsr_pkg::OVERHEAD);
                    run_sum = 16'hFFFF - it.rx;
                    phase = P_DATA;
                end
                P_DATA: begin
                    body[body_idx] = it.rx;
                    body_idx++;
                    run_sum -= it.rx;
                    if (body_idx >= body_len) phase = P_CHKL;
                end
                P_CHKL: begin
                    chk_lo = it.rx; phase = P_CHKH;
                end
                default: begin
                    phase = P_LEN;
                    if (run_sum == {it.rx, chk_lo}) begin
                        if (good_cnt != '1) good_cnt++;
                        if (body[0] == ibrsr_pkg::CMD_SERVO) begin
                            for (int i = 0; i < ibrsr_pkg::CHANNELS; i++)
                                push_result(ibrsr_pkg::KIND_CHANNEL, i[3:0],
                                            {body[(2 * i + 2) % 32], body[(2 * i + 1) % 32]},
                                            '0, i == ibrsr_pkg::CHANNELS - 1);
                        end else begin
                            predict_reply();
                        end
                    end else begin
                        if (bad_cnt != '1) bad_cnt++;
                        push_result(ibrsr_pkg::KIND_ERROR, '0, '0, '0, 1'b1);
                    end
                end
            endcase
        end
    endtask

    // Driver. A transaction that is waiting keeps its valid and data until accepted.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) predict_item(pending_items.pop_front());
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (!hold_tx && pending_items.size() > 0
                && $urandom_range(99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_items[0].op;
                s_axis_tdata <= {4'b0, pending_items[0].val, pending_items[0].adr,
                                 pending_items[0].rx};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Monitor.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tuser, 0);
            end else begin
                e = expected_results.pop_front();
                if (m_axis_tuser !== e.kind) report_mismatch("kind", m_axis_tuser, e.kind);
                if (m_axis_tdata[3:0] !== e.chan)
                    report_mismatch("channel_index", m_axis_tdata[3:0], e.chan);
                if (m_axis_tdata[19:4] !== e.value)
                    report_mismatch("channel_value", m_axis_tdata[19:4], e.value);
                if (m_axis_tdata[27:20] !== e.rbyte)
                    report_mismatch("reply_byte", m_axis_tdata[27:20], e.rbyte);
                if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
                if (m_axis_tdata[59:28] !== e.good)
                    report_mismatch("good_frame_count", m_axis_tdata[59:28], e.good);
                if (m_axis_tdata[91:60] !== e.bad)
                    report_mismatch("error_frame_count", m_axis_tdata[91:60], e.bad);
            end
        end
    end

    // Watchdog: any accepted transaction restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > 20000) begin
            $display("[ibus_receiver_sensor_responder_top] ERROR");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] op, logic [7:0] rx, logic [3:0] adr, logic [31:0] v);
        t_item it;
        it.op = op; it.rx = rx; it.adr = adr; it.val = v;
        pending_items.push_back(it);
    endtask

    // Queues a frame of length byte, body and checksum; corrupt flips one checksum bit.
    task automatic add_frame(logic [7:0] body_bytes[$], bit corrupt);
        logic [15:0] ck;
        ck = 16'hFFFF - 16'(body_bytes.size() + 3);
        add_item(ibrsr_pkg::IN_BYTE, 8'(body_bytes.size() + 3), '0, '0);
        foreach (body_bytes[i]) begin
            add_item(ibrsr_pkg::IN_BYTE, body_bytes[i], '0, '0);
            ck -= body_bytes[i];
        end
        if (corrupt) ck ^= 16'(1 << $urandom_range(15));
        add_item(ibrsr_pkg::IN_BYTE, ck[7:0], '0, '0);
        add_item(ibrsr_pkg::IN_BYTE, ck[15:8], '0, '0);
        frames_sent++;
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1; i_cfg_index <= idx; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            ibrsr_pkg::REG_SENSOR_COUNT: cfg_count = v[3:0];
            ibrsr_pkg::REG_SENSOR_TYPES: cfg_types = v;
            ibrsr_pkg::REG_WIDE_MASK:    cfg_wide = v[7:0];
            ibrsr_pkg::REG_GAP_TIMEOUT:  cfg_gap = v[7:0];
            ibrsr_pkg::REG_REPLY_ENABLE: cfg_reply = v[0];
            default: ;
        endcase
    endtask

    task automatic random_phase(int n);
        logic [7:0] b[$];
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            b = {};
            if (sel < 30) begin
                b.push_back(ibrsr_pkg::CMD_SERVO);
                repeat ($urandom_range(1, 28)) b.push_back(8'($urandom));
                add_frame(b, $urandom_range(9) == 0);
            end else if (sel < 60) begin
                b.push_back({ibrsr_pkg::CMD_DISCOVER + 4'($urandom_range(2)),
                             4'($urandom_range(9))});
                add_frame(b, $urandom_range(9) == 0);
            end else if (sel < 72) begin
                add_item(ibrsr_pkg::IN_VALUE, '0, 4'($urandom_range(15)), $urandom);
            end else if (sel < 82) begin
                repeat ($urandom_range(1, 6)) add_item(ibrsr_pkg::IN_TICK, '0, '0, '0);
            end else if (sel < 92) begin
                repeat ($urandom_range(1, 8)) b.push_back(8'($urandom));
                add_frame(b, $urandom_range(1) == 0);
            end else begin
                repeat ($urandom_range(1, 5)) add_item(2'($urandom_range(3)), 8'($urandom),
                                                       4'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        logic [7:0] b[$];
        cfg_count = 0; cfg_types = 0; cfg_wide = 0; cfg_gap = 8'd3; cfg_reply = 1'b1;
        phase = P_LEN; body_len = 0; body_idx = 0; run_sum = 0; chk_lo = 0;
        idle_ms = 0; good_cnt = 0; bad_cnt = 0;
        foreach (body[i]) body[i] = '0;
        foreach (sensor_val[i]) sensor_val[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Servo frame after reset: short body reads zeros beyond it.
        b = {ibrsr_pkg::CMD_SERVO, 8'hFF, 8'h00}; add_frame(b, 0);
        // Reply with no sensors configured: good frame, no result.
        b = {8'h81}; add_frame(b, 0);
        b = {8'h12, 8'h34}; add_frame(b, 1);
        add_item(ibrsr_pkg::IN_BYTE, 8'd3, '0, '0);    // bad length, ignored
        add_item(ibrsr_pkg::IN_BYTE, 8'd33, '0, '0);   // above frame size, ignored
        add_item(ibrsr_pkg::IN_VALUE, '0, 4'd1, 32'h8000_0000);
        add_item(OP_UNUSED, 8'hFF, 4'hF, 32'hFFFF_FFFF);
        wait_drained();

        write_reg(ibrsr_pkg::REG_SENSOR_COUNT, 64'd15);  // clamps to eight
        write_reg(ibrsr_pkg::REG_SENSOR_TYPES, 64'hFEDC_BA98_7654_3210);
        write_reg(ibrsr_pkg::REG_WIDE_MASK, 64'hAA);
        write_reg(ibrsr_pkg::REG_GAP_TIMEOUT, 64'd1);
        write_reg(ibrsr_pkg::REG_REPLY_ENABLE, 64'd1);
        add_item(ibrsr_pkg::IN_VALUE, '0, 4'd2, 32'h7FFF_FFFF);
        add_item(ibrsr_pkg::IN_VALUE, '0, 4'd9, 32'h1234_5678);  // out of range
        b = {8'h82}; add_frame(b, 0);
        b = {8'h92}; add_frame(b, 0);
        b = {8'hA2}; add_frame(b, 0);
        b = {8'hA1}; add_frame(b, 0);
        // Gap in mid-frame: the next byte restarts as a length byte.
        add_item(ibrsr_pkg::IN_BYTE, 8'd4, '0, '0);
        add_item(ibrsr_pkg::IN_TICK, '0, '0, '0);
        b = {8'h88}; add_frame(b, 0);
        b = {ibrsr_pkg::CMD_SERVO}; repeat (28) b.push_back(8'($urandom)); add_frame(b, 0);
        random_phase(8);
        wait_drained();

        tx_idle_pct = 61; rx_idle_pct = 12;
        write_reg(ibrsr_pkg::REG_SENSOR_COUNT, 64'd4);
        write_reg(ibrsr_pkg::REG_WIDE_MASK, 64'h05);
        write_reg(ibrsr_pkg::REG_GAP_TIMEOUT, 64'd255);
        random_phase(7);
        // Hold the sender partway through until the block has delivered everything.
        while (pending_items.size() > 20) @(posedge i_clk);
        hold_tx = 1'b1;
        repeat (2) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        hold_tx = 1'b0;
        wait_drained();

        tx_idle_pct = 0; rx_idle_pct = 0;
        write_reg(ibrsr_pkg::REG_SENSOR_COUNT, 64'd8);
        write_reg(ibrsr_pkg::REG_GAP_TIMEOUT, 64'd3);
        write_reg(ibrsr_pkg::REG_REPLY_ENABLE, 64'd0);
        random_phase(4);
        wait_drained();
        write_reg(ibrsr_pkg::REG_REPLY_ENABLE, 64'd1);
        write_reg(ibrsr_pkg::REG_SENSOR_COUNT, 64'd0);
        random_phase(4);
        wait_drained();

        $display("Covered %0d frames and %0d result transactions over four settings,",
                 frames_sent, results_seen);
        $display("with servo, sensor reply, error, gap and sensor write traffic.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ibus_receiver_sensor_responder_top] OK");
        end else begin
            $display("[ibus_receiver_sensor_responder_top] ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
design/ibrsr_pkg.sv
design/ibrsr_ram.sv
design/ibrsr_datapath.sv
design/ibrsr_ctrl.sv
design/ibus_receiver_sensor_responder_top.sv
dv/tb_ibus_receiver_sensor_responder_top.sv
